FILE: rtl/core/bsfb_pkg.sv
`default_nettype none
package bsfb_pkg;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int FLEN_W = 18;
    localparam int CFG_IDX_W = 2;

    // Command queue depth between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MARKER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MARKER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_MARKER    = 2'd3;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] RST_DEVICE_ADDRESS = 8'd0;
    localparam logic [BYTE_W-1:0] RST_HEADER_MARKER  = 8'd170;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_MARKER  = 8'd165;
    localparam logic [BYTE_W-1:0] RST_TAIL_MARKER    = 8'd85;

    typedef struct packed {
        logic [BYTE_W-1:0] device_address;
        logic [BYTE_W-1:0] header_marker;
        logic [BYTE_W-1:0] escape_marker;
        logic [BYTE_W-1:0] tail_marker;
    } cfg_t;

    // One classified command: a frame start or a payload byte
    typedef struct packed {
        logic              is_start;
        logic              close;     // frame ends after this command
        logic [BYTE_W-1:0] arg_byte;  // function code on start, data on payload
        logic [LEN_W-1:0]  len;       // payload length on start
    } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/bsfb_front.sv
`default_nettype none
module bsfb_front
    import bsfb_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              opcode,
    input  wire logic [BYTE_W-1:0] function_code,
    input  wire logic [LEN_W-1:0]  payload_length,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              q_full,
    output logic                   q_push,
    output cmd_t                   q_cmd
);

    logic                   open_reg, open_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [LENGTH_BITS-1:0] len_m;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic                   accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign len_m    = payload_length[LENGTH_BITS-1:0];
    assign rem_dec  = remain_reg - LENGTH_BITS'(1);

    // Classify the word and track how much payload the open frame still needs
    always_comb
    begin
        open_next   = open_reg;
        remain_next = remain_reg;
        q_push      = 1'b0;
        q_cmd       = '0;
        if (accept)
        begin
            if (opcode == OP_START)
            begin
                q_push         = 1'b1;
                q_cmd.is_start = 1'b1;
                q_cmd.close    = (len_m == '0);
                q_cmd.arg_byte = function_code;
                q_cmd.len      = LEN_W'(len_m);
                remain_next    = len_m;
                open_next      = (len_m != '0);
            end
            else if (open_reg)
            begin
                q_push         = 1'b1;
                q_cmd.is_start = 1'b0;
                q_cmd.close    = (rem_dec == '0);
                q_cmd.arg_byte = data_byte;
                remain_next    = rem_dec;
                open_next      = (rem_dec != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bsfb_fifo.sv
`default_nettype none
module bsfb_fifo
    import bsfb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    input  wire logic pop,
    output cmd_t      head_cmd,
    output logic      full,
    output logic      empty
);

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                        : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                        : rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command popped from empty queue");

endmodule
`default_nettype wire

FILE: rtl/core/bsfb_back.sv
`default_nettype none
module bsfb_back
    import bsfb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  cfg_t                    cfg,
    input  cmd_t                    head_cmd,
    input  wire logic               q_empty,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [BYTE_W-1:0]       out_byte,
    output logic                    last_of_run,
    output logic                    end_of_frame,
    output logic [FLEN_W-1:0]       frame_length
);

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_HM1  = 13'b0000000000010,
        ST_HM2  = 13'b0000000000100,
        ST_DEV  = 13'b0000000001000,
        ST_FC   = 13'b0000000010000,
        ST_SA0  = 13'b0000000100000,
        ST_SA1  = 13'b0000001000000,
        ST_LLO  = 13'b0000010000000,
        ST_LHI  = 13'b0000100000000,
        ST_DATA = 13'b0001000000000,
        ST_CSUM = 13'b0010000000000,
        ST_TL1  = 13'b0100000000000,
        ST_TL2  = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic                esc_done_reg, esc_done_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [FLEN_W-1:0]   count_reg, count_next;
    logic [BYTE_W-1:0]   arg_reg, arg_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                close_reg, close_next;

    logic                ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0]   obyte_reg, obyte_next;
    logic                olast_reg, olast_next;
    logic                oeof_reg, oeof_next;
    logic [FLEN_W-1:0]   oflen_reg, oflen_next;

    logic                out_free;
    logic                emit;
    logic [BYTE_W-1:0]   cur_byte;
    logic                stuffed;
    logic                counted;
    logic                ends_item;
    logic                needs_esc;
    state_t              follow;

    assign out_free = !ovalid_reg || !out_stall;

    // Byte for the current step and its class
    always_comb
    begin
        cur_byte = '0;
        stuffed  = 1'b0;
        counted  = 1'b0;
        follow   = ST_IDLE;
        case (state_reg)
            ST_HM1:  begin cur_byte = cfg.header_marker; follow = ST_HM2; end
            ST_HM2:  begin cur_byte = cfg.header_marker; follow = ST_DEV; end
            ST_DEV:
            begin
                cur_byte = cfg.device_address;
                stuffed  = 1'b1;
                counted  = 1'b1;
                follow   = ST_FC;
            end
            ST_FC:
            begin
                cur_byte = arg_reg;
                stuffed  = 1'b1;
                counted  = 1'b1;
                follow   = ST_SA0;
            end
            ST_SA0:  begin stuffed = 1'b1; counted = 1'b1; follow = ST_SA1; end
            ST_SA1:  begin stuffed = 1'b1; counted = 1'b1; follow = ST_LLO; end
            ST_LLO:
            begin
                cur_byte = len_reg[7:0];
                stuffed  = 1'b1;
                counted  = 1'b1;
                follow   = ST_LHI;
            end
            ST_LHI:
            begin
                cur_byte = len_reg[15:8];
                stuffed  = 1'b1;
                counted  = 1'b1;
                follow   = ST_CSUM;
            end
            ST_DATA:
            begin
                cur_byte = arg_reg;
                stuffed  = 1'b1;
                counted  = 1'b1;
                follow   = ST_CSUM;
            end
            ST_CSUM: begin cur_byte = sum_reg; stuffed = 1'b1; follow = ST_TL1; end
            ST_TL1:  begin cur_byte = cfg.tail_marker; follow = ST_TL2; end
            ST_TL2:  begin cur_byte = cfg.tail_marker; follow = ST_IDLE; end
            default: begin cur_byte = '0; follow = ST_IDLE; end
        endcase
    end

    assign needs_esc = stuffed && !esc_done_reg
                    && (cur_byte == cfg.escape_marker
                        || cur_byte == cfg.header_marker
                        || cur_byte == cfg.tail_marker);

    assign ends_item = (state_reg == ST_TL2)
                    || (((state_reg == ST_LHI) || (state_reg == ST_DATA)) && !close_reg);

    // Sequencer: one output byte per free cycle, next command loaded on the last byte
    always_comb
    begin
        state_next    = state_reg;
        esc_done_next = esc_done_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        arg_next      = arg_reg;
        len_next      = len_reg;
        close_next    = close_reg;
        q_pop         = 1'b0;
        emit          = 1'b0;
        obyte_next    = obyte_reg;
        olast_next    = olast_reg;
        oeof_next     = oeof_reg;
        oflen_next    = oflen_reg;

        if (state_reg == ST_IDLE)
        begin
            q_pop = !q_empty;
        end
        else if (out_free)
        begin
            emit       = 1'b1;
            olast_next = 1'b0;
            oeof_next  = 1'b0;
            oflen_next = '0;
            count_next = (state_reg == ST_HM1) ? FLEN_W'(1) : count_reg + FLEN_W'(1);
            if (needs_esc)
            begin
                obyte_next    = cfg.escape_marker;
                esc_done_next = 1'b1;
            end
            else
            begin
                obyte_next    = cur_byte;
                esc_done_next = 1'b0;
                if (state_reg == ST_HM1)
                begin
                    sum_next = '0;
                end
                else if (counted)
                begin
                    sum_next = sum_reg + cur_byte;
                end
                if (state_reg == ST_TL2)
                begin
                    oeof_next  = 1'b1;
                    oflen_next = count_next;
                end
                if (ends_item)
                begin
                    olast_next = 1'b1;
                    q_pop      = !q_empty;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = follow;
                end
            end
        end

        if (q_pop)
        begin
            state_next = head_cmd.is_start ? ST_HM1 : ST_DATA;
            arg_next   = head_cmd.arg_byte;
            len_next   = head_cmd.len;
            close_next = head_cmd.close;
        end
    end

    // Output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            esc_done_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
            close_reg    <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            esc_done_reg <= esc_done_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            close_reg    <= close_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        arg_reg   <= arg_next;
        len_reg   <= len_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        oeof_reg  <= oeof_next;
        oflen_reg <= oflen_next;
    end

    assign out_valid    = ovalid_reg;
    assign out_byte     = obyte_reg;
    assign last_of_run  = olast_reg;
    assign end_of_frame = oeof_reg;
    assign frame_length = oflen_reg;

    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && oeof_reg) |-> olast_reg)
        else $error("frame end without end of run");

    a_flen_only_at_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !oeof_reg) |-> (oflen_reg == '0))
        else $error("frame length outside frame end");

    a_escape_holds_step: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && needs_esc) |=> (esc_done_reg && $stable(state_reg)))
        else $error("escape byte did not hold the step");

endmodule
`default_nettype wire

FILE: rtl/core/byte_stuffed_frame_builder.sv
// Byte-stuffed frame builder.
// Input channel (in_valid / in_stall): opcode 0 opens a frame with function_code and
// payload_length; opcode 1 carries one data_byte. Payload words with no open frame
// are taken and dropped. A start word drops any open frame without a tail.
// Output channel (out_valid / out_stall): one frame byte per word; last_of_run marks
// the last byte caused by an input word, end_of_frame and frame_length mark the
// second tail byte.
// Config port (cfg_we / cfg_index / cfg_data): device address, header, escape and
// tail markers; write only while the block is idle.
// The first output byte passes the queue, the sequencer state and the output register.
// The sequencer sends one byte per cycle while not stalled and with commands queued:
// a payload word yields one byte, two when escaped, a start word 8 to 14 bytes and a
// frame close 3 or 4 more. A two-entry command queue lets input run ahead of it.
// When the receiver stalls, the output register holds its byte, the sequencer waits
// and the queue fills; in_stall rises only when the queue is full.
// Reset clears the queue, closes any frame and loads the default markers.
`default_nettype none
module byte_stuffed_frame_builder
    import bsfb_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 opcode,
    input  wire logic [BYTE_W-1:0]    function_code,
    input  wire logic [LEN_W-1:0]     payload_length,
    input  wire logic [BYTE_W-1:0]    data_byte,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [BYTE_W-1:0]         out_byte,
    output logic                      last_of_run,
    output logic                      end_of_frame,
    output logic [FLEN_W-1:0]         frame_length
);

    cfg_t cfg_reg, cfg_next;
    cmd_t push_cmd, head_cmd;
    logic q_push, q_pop, q_full, q_empty;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_next.device_address = cfg_data;
                CFG_HEADER_MARKER:  cfg_next.header_marker  = cfg_data;
                CFG_ESCAPE_MARKER:  cfg_next.escape_marker  = cfg_data;
                CFG_TAIL_MARKER:    cfg_next.tail_marker    = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= RST_DEVICE_ADDRESS;
            cfg_reg.header_marker  <= RST_HEADER_MARKER;
            cfg_reg.escape_marker  <= RST_ESCAPE_MARKER;
            cfg_reg.tail_marker    <= RST_TAIL_MARKER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bsfb_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .function_code  (function_code),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (push_cmd)
    );

    bsfb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    bsfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_cmd     (head_cmd),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame),
        .frame_length (frame_length)
    );

endmodule
`default_nettype wire
